// ===== rtl/sem_pkg.sv =====
// shared types and constants for the sobel edge magnitude filter
package sem_pkg;

   localparam int DEFAULT_MAX_WIDTH = 1024;
   localparam int HEIGHT_LIMIT      = 1024;
   localparam int MIN_DIM           = 3;
   localparam int PIX_BITS          = 8;
   localparam int CFG_BITS          = 11;
   localparam int CSR_DATA_BITS     = 32;
   localparam int CSR_ADDR_BITS     = 3;

   localparam logic [PIX_BITS-1:0] PIX_MAX = 8'hFF;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // 3x3 neighbourhood, [row][column], row 0 on top, column 0 oldest
   typedef logic [2:0][2:0][PIX_BITS-1:0] window_type;

endpackage

// ===== rtl/sem_kernel.sv =====
// sobel gradient kernels with saturated l1 magnitude
module sem_kernel (
   input  sem_pkg::window_type          win,
   output logic [sem_pkg::PIX_BITS-1:0] magnitude
);
   import sem_pkg::*;

   logic [PIX_BITS+1:0] right_sum;
   logic [PIX_BITS+1:0] left_sum;
   logic [PIX_BITS+1:0] top_sum;
   logic [PIX_BITS+1:0] bottom_sum;
   logic [PIX_BITS+1:0] abs_x;
   logic [PIX_BITS+1:0] abs_y;
   logic [PIX_BITS+2:0] total;

   // weights 1 2 1 along each kernel edge
   assign right_sum  = 10'(win[0][2]) + {1'b0, win[1][2], 1'b0} + 10'(win[2][2]);
   assign left_sum   = 10'(win[0][0]) + {1'b0, win[1][0], 1'b0} + 10'(win[2][0]);
   assign top_sum    = 10'(win[0][0]) + {1'b0, win[0][1], 1'b0} + 10'(win[0][2]);
   assign bottom_sum = 10'(win[2][0]) + {1'b0, win[2][1], 1'b0} + 10'(win[2][2]);

   assign abs_x = (right_sum >= left_sum) ? right_sum - left_sum : left_sum - right_sum;
   assign abs_y = (top_sum >= bottom_sum) ? top_sum - bottom_sum : bottom_sum - top_sum;
   assign total = {1'b0, abs_x} + {1'b0, abs_y};

   assign magnitude = (total > 11'(PIX_MAX)) ? PIX_MAX : total[PIX_BITS-1:0];

endmodule

// ===== rtl/sobel_edge_magnitude_filter.sv =====
// sobel edge magnitude filter top level: line stores, window and beat handshakes
//
// pixels enter on the req_ channel in raster order, one beat per pixel;
// req_frame_start marks the first pixel of a frame and clears the position
// counters. for every pixel at row >= 2 and column >= 2 one beat leaves on the
// rsp_ channel carrying |gx| + |gy| of the centre one row up and one column left,
// saturated to 255; rsp_last flags the final interior pixel of the frame.
// border pixels give no beat.
// pixels pass stage one, then the result register; one pixel per cycle is sustained
// while the receiver is ready, set by the single read and write port of each line
// store. a stalled receiver holds the result register, and the input side keeps
// taking beats until stage one is full too. image_width (address 0) and image_height
// (address 4) are written over the csr_ port; the user must write them only while
// no beat is in flight, which the block does not enforce. values are clamped to
// [3, MAX_WIDTH] and [3, 1024]. reset empties the pipeline, clears the counters and
// sets both registers to 1024; line store contents stay undefined until written.
module sobel_edge_magnitude_filter #(
   parameter int MAX_WIDTH = sem_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sem_pkg::PIX_BITS-1:0]       req_pixel,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sem_pkg::PIX_BITS-1:0]       rsp_edge_res,
   output logic                               rsp_last,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sem_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [sem_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [sem_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);
   import sem_pkg::*;

   localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW = CW + 1;
   localparam int RW = $clog2(HEIGHT_LIMIT);

   // configuration registers
   logic [CFG_BITS-1:0] image_width_ff;
   logic [CFG_BITS-1:0] image_height_ff;
   logic                csr_we;
   reg_index_type       csr_index;
   logic [EW-1:0]       eff_width;
   logic [CFG_BITS-1:0] eff_height;

   // position counters
   logic [CW-1:0]       col_ff, col_in, cur_col;
   logic [RW-1:0]       row_ff, row_in, cur_row;
   logic [EW-1:0]       col_inc;
   logic [RW:0]         row_inc;
   logic                col_wrap;
   logic                cur_produce;
   logic                cur_last;
   logic                req_acc;

   // stage in front of the result register
   logic                s1_valid_ff;
   logic                s1_produce_ff;
   logic                s1_last_ff;
   logic [CW-1:0]       s1_idx_ff;
   logic [PIX_BITS-1:0] s1_pixel_ff;
   logic [PIX_BITS-1:0] upper_rd_ff;
   logic [PIX_BITS-1:0] mid_rd_ff;
   logic                s1_hit_ff;
   logic [PIX_BITS-1:0] fwd_ff;
   logic                hit_in;
   logic                s1_adv;
   logic                out_free;
   logic [PIX_BITS-1:0] col_upper;

   // line stores and window
   logic [PIX_BITS-1:0] upper_mem [MAX_WIDTH];
   logic [PIX_BITS-1:0] mid_mem   [MAX_WIDTH];
   logic [1:0][2:0][PIX_BITS-1:0] win_ff;
   window_type          win;
   logic [PIX_BITS-1:0] magnitude;

   // result register
   logic                rsp_valid_ff;
   logic [PIX_BITS-1:0] rsp_edge_res_ff;
   logic                rsp_last_ff;

   // configuration port
   assign pready    = 1'b1;
   assign csr_we    = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= CFG_BITS'(DEFAULT_MAX_WIDTH);
         image_height_ff <= CFG_BITS'(HEIGHT_LIMIT);
      end else if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[CFG_BITS-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= pwdata[CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_BITS'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_BITS'(image_height_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      if (image_width_ff < CFG_BITS'(MIN_DIM)) begin
         eff_width = EW'(MIN_DIM);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = EW'(image_width_ff);
      end
      if (image_height_ff < CFG_BITS'(MIN_DIM)) begin
         eff_height = CFG_BITS'(MIN_DIM);
      end else if (image_height_ff > CFG_BITS'(HEIGHT_LIMIT)) begin
         eff_height = CFG_BITS'(HEIGHT_LIMIT);
      end else begin
         eff_height = image_height_ff;
      end
   end

   // handshakes
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || s1_adv;
   assign req_acc   = req_valid && req_ready;

   // position of the incoming pixel
   assign cur_col     = req_frame_start ? '0 : col_ff;
   assign cur_row     = req_frame_start ? '0 : row_ff;
   assign col_inc     = {1'b0, cur_col} + EW'(1);
   assign row_inc     = {1'b0, cur_row} + (RW+1)'(1);
   assign col_wrap    = col_inc >= eff_width;
   assign cur_produce = (cur_row >= RW'(2)) && (cur_col >= CW'(2));
   assign cur_last    = ((RW+1)'(cur_row) == eff_height - CFG_BITS'(1))
                        && ({1'b0, cur_col} == eff_width - EW'(1));

   always_comb begin
      col_in = col_wrap ? '0 : col_inc[CW-1:0];
      row_in = cur_row;
      if (col_wrap) begin
         row_in = (CFG_BITS'(row_inc) >= eff_height) ? '0 : row_inc[RW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line stores: middle written on input, upper written as the beat leaves stage one
   assign hit_in = s1_adv && (s1_idx_ff == cur_col);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         mid_rd_ff       <= mid_mem[cur_col];
         mid_mem[cur_col] <= req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         upper_rd_ff <= upper_mem[cur_col];
      end
      if (s1_adv) begin
         upper_mem[s1_idx_ff] <= mid_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_produce_ff <= cur_produce;
         s1_last_ff    <= cur_last;
         s1_idx_ff     <= cur_col;
         s1_pixel_ff   <= req_pixel;
         s1_hit_ff     <= hit_in;
         fwd_ff        <= mid_rd_ff;
      end
   end

   // newest column of the window, upper pixel bypassed when the store write is in flight
   assign col_upper = s1_hit_ff ? fwd_ff : upper_rd_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win_ff[0][r];
         win[r][1] = win_ff[1][r];
      end
      win[0][2] = col_upper;
      win[1][2] = mid_rd_ff;
      win[2][2] = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         win_ff[0]    <= win_ff[1];
         win_ff[1][0] <= col_upper;
         win_ff[1][1] <= mid_rd_ff;
         win_ff[1][2] <= s1_pixel_ff;
      end
   end

   sem_kernel u_kernel (
      .win       (win),
      .magnitude (magnitude)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= s1_produce_ff;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_produce_ff) begin
         rsp_edge_res_ff <= magnitude;
         rsp_last_ff     <= s1_last_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_edge_res = rsp_edge_res_ff;
   assign rsp_last     = rsp_last_ff;

   // checks
   frame_start_restarts_row: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_frame_start |=> col_ff == CW'(1) && row_ff == '0)
      else $error("frame start beat did not restart the position counters");

   last_pixel_wraps: assert property (@(posedge clock) disable iff (reset)
      req_acc && cur_last |=> col_ff == '0 && row_ff == '0)
      else $error("counters did not wrap after the last pixel of the frame");

   reset_empties_pipe: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff && req_ready)
      else $error("pipeline not empty after reset");

   bypass_only_on_same_column: assert property (@(posedge clock) disable iff (reset)
      req_acc && hit_in |=> s1_hit_ff && s1_idx_ff == $past(s1_idx_ff))
      else $error("line store bypass taken for a different column");

endmodule
